// ----- rtl/spwm_pkg.sv -----
// ============================================================================
// spwm_pkg
// Shared types and codes for the three-phase sine PWM reference unit:
// controller states, the controller-to-datapath command bundle, register
// indexes and phase selects.
// ============================================================================
package spwm_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PHASE,
        ST_INDEX,
        ST_READ,
        ST_MUL,
        ST_STORE,
        ST_PUBLISH
    } state_t;

    // Phase selects (A, B, C)
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [1:0] CFG_AMPLITUDE    = 2'd1;
    localparam logic [1:0] CFG_CARRIER_HALF = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       accept;      // input transaction taken this cycle
        logic       mul_scale;   // multiplier: amplitude * carrier_half
        logic       ph_calc;     // phase of the selected output
        logic       idx_calc;    // ROM index from phase
        logic       rom_read;    // registered ROM read
        logic       mul_level;   // multiplier: scale * (half + sine)
        logic       store_level; // saturate and keep level of selected phase
        logic       out_load;    // move levels into output registers
        logic [1:0] sel;         // phase being worked on
    } cmd_t;

endpackage

// ----- rtl/three_phase_sine_pwm_reference_unit.sv -----
// ============================================================================
// three_phase_sine_pwm_reference_unit
// Three-phase sine PWM reference: phase accumulator, sine ROM lookup and
// amplitude scaling to three saturated compare levels.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ------------------------------
//  input     in         in_valid / in_stall  advance
//  output    out        out_valid/out_stall  level_a, level_b, level_c
//  config    in         cfg_wr_en            cfg_index, cfg_data
//
//  One transaction runs from accept to publish: first the
//  amplitude * carrier_half product, then for each phase the phase,
//  index, registered sine ROM read, shared multiplier and store steps.
//  Then it publishes; no new input is accepted until it is back in idle.
//  A new transaction is taken once the previous result is in the output
//  register; it may wait there under out_stall while the next one runs.
//  Reset clears the phase accumulator and loads the register defaults.
//
module three_phase_sine_pwm_reference_unit #(
    parameter int TABLE_DEPTH = 512,
    parameter int PHASE_WIDTH = 32,
    parameter int LEVEL_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   advance,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_WIDTH-1:0] level_a,
    output logic [LEVEL_WIDTH-1:0] level_b,
    output logic [LEVEL_WIDTH-1:0] level_c,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [PHASE_WIDTH-1:0] cfg_data
);
    import spwm_pkg::*;

    cmd_t cmd;

    // Sequencer
    spwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath
    spwm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PHASE_WIDTH (PHASE_WIDTH),
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .advance   (advance),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .level_a   (level_a),
        .level_b   (level_b),
        .level_c   (level_c)
    );

endmodule

// ----- rtl/spwm_ctrl.sv -----
// ============================================================================
// spwm_ctrl
// Sequencer for the reference unit: takes one input transaction, walks the
// shared multiplier and sine ROM through phases A, B and C, then publishes.
// ============================================================================
module spwm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output spwm_pkg::cmd_t cmd
);
    import spwm_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                sel_next = PH_A;
                if (in_valid)
                    state_next = ST_SCALE;
            end
            ST_SCALE:   state_next = ST_PHASE;
            ST_PHASE:   state_next = ST_INDEX;
            ST_INDEX:   state_next = ST_READ;
            ST_READ:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_STORE;
            ST_STORE:
            begin
                if (sel_reg == PH_C)
                    state_next = ST_PUBLISH;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_PHASE;
                end
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    sel_next   = PH_A;
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd     = '0;
        cmd.sel = sel_reg;
        unique case (state_reg)
            ST_IDLE:    cmd.accept      = in_valid;
            ST_SCALE:   cmd.mul_scale   = 1'b1;
            ST_PHASE:   cmd.ph_calc     = 1'b1;
            ST_INDEX:   cmd.idx_calc    = 1'b1;
            ST_READ:    cmd.rom_read    = 1'b1;
            ST_MUL:     cmd.mul_level   = 1'b1;
            ST_STORE:   cmd.store_level = 1'b1;
            ST_PUBLISH: cmd.out_load    = out_free;
            default:    cmd.sel         = sel_reg;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= PH_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted transaction did not start the sequence");

    a_rise_after_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_PUBLISH))
        else $error("result shown without publish");

    a_idle_sel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> sel_reg == PH_A)
        else $error("phase select not cleared in idle");

    a_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STORE && sel_reg == PH_C |=> state_reg == ST_PUBLISH)
        else $error("sequence did not end after phase C");

endmodule

// ----- rtl/spwm_datapath.sv -----
// ============================================================================
// spwm_datapath
// Phase accumulator, configuration registers, sine ROM with registered read,
// one shared multiplier and the level/output registers.
// ============================================================================
module spwm_datapath #(
    parameter int TABLE_DEPTH = 512,
    parameter int PHASE_WIDTH = 32,
    parameter int LEVEL_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spwm_pkg::cmd_t         cmd,
    input  logic                   advance,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [PHASE_WIDTH-1:0] cfg_data,
    output logic [LEVEL_WIDTH-1:0] level_a,
    output logic [LEVEL_WIDTH-1:0] level_b,
    output logic [LEVEL_WIDTH-1:0] level_c
);
    import spwm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [PHASE_WIDTH-1:0] OFFSET_B =
        PHASE_WIDTH'(((64'd1 << PHASE_WIDTH) + 64'd1) / 64'd3);
    localparam logic [PHASE_WIDTH-1:0] OFFSET_C =
        PHASE_WIDTH'(((64'd2 << PHASE_WIDTH) + 64'd1) / 64'd3);
    localparam logic [17:0] LEVEL_MAX = (18'd1 << LEVEL_WIDTH) - 18'd1;

    // Q1.15 sine of a 32-bit turn fraction, polynomial in Q30
    function automatic logic signed [15:0] sine_q15(input logic [31:0] p);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        logic [1:0]  quad;
        quad = p[31:30];
        r    = {34'd0, p[29:0]};
        if (quad[0])
            r = Q30_ONE - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
            q = 64'd32767;
        return quad[1] ? $signed(16'd0 - q[15:0]) : $signed(q[15:0]);
    endfunction

    typedef logic signed [15:0] rom_t [TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i < TABLE_DEPTH; i++)
            rom[i] = sine_q15(32'((64'(i) << 32) / 64'(TABLE_DEPTH)));
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PHASE_WIDTH-1:0] step_reg;
    logic [14:0]            amp_reg;
    logic [15:0]            half_reg;
    logic [PHASE_WIDTH-1:0] acc_reg;
    logic [PHASE_WIDTH-1:0] ph_reg;
    logic [PHASE_WIDTH-1:0] ph_offset;
    logic [IDX_W-1:0]       idx_reg;
    logic [PHASE_WIDTH+IDX_W-1:0] idx_prod;
    logic signed [15:0]     rom_reg;
    logic [30:0]            scale_reg;
    logic [30:0]            mul_a;
    logic [15:0]            mul_b;
    logic [46:0]            mul_reg;
    logic [17:0]            lvl_raw;
    logic [LEVEL_WIDTH-1:0] lvl_sat;
    logic [LEVEL_WIDTH-1:0] lvl_a_reg, lvl_b_reg, lvl_c_reg;
    logic [LEVEL_WIDTH-1:0] level_a_reg, level_b_reg, level_c_reg;

    // Configuration registers and phase accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= PHASE_WIDTH'(429497);
            amp_reg  <= 15'd16384;
            half_reg <= 16'd500;
            acc_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_PHASE_STEP:   step_reg <= cfg_data;
                    CFG_AMPLITUDE:    amp_reg  <= cfg_data[14:0];
                    CFG_CARRIER_HALF: half_reg <= cfg_data[15:0];
                    default:          step_reg <= step_reg;
                endcase
            end
            if (cmd.accept && advance)
                acc_reg <= acc_reg + step_reg;
        end
    end

    // Offset of the selected phase
    always_comb
    begin
        case (cmd.sel)
            PH_B:    ph_offset = OFFSET_B;
            PH_C:    ph_offset = OFFSET_C;
            default: ph_offset = '0;
        endcase
    end

    // ROM index: (phase * depth) >> phase width
    assign idx_prod = {{IDX_W{1'b0}}, ph_reg} * (PHASE_WIDTH+IDX_W)'(TABLE_DEPTH);

    // Shared multiplier operands
    assign mul_a = cmd.mul_scale ? {16'd0, amp_reg} : scale_reg;
    assign mul_b = cmd.mul_scale ? half_reg : {~rom_reg[15], rom_reg[14:0]};

    // Level from product, saturated
    assign lvl_raw = mul_reg[46:29];
    assign lvl_sat = (lvl_raw > LEVEL_MAX) ? LEVEL_MAX[LEVEL_WIDTH-1:0]
                                           : lvl_raw[LEVEL_WIDTH-1:0];

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.ph_calc)
            ph_reg <= acc_reg + ph_offset;
        if (cmd.ph_calc && cmd.sel == PH_A)
            scale_reg <= mul_reg[30:0];
        if (cmd.idx_calc)
            idx_reg <= idx_prod[PHASE_WIDTH +: IDX_W];
        if (cmd.rom_read)
            rom_reg <= SINE_ROM[idx_reg];
        if (cmd.mul_scale || cmd.mul_level)
            mul_reg <= 47'(mul_a) * 47'(mul_b);
        if (cmd.store_level)
        begin
            case (cmd.sel)
                PH_A:    lvl_a_reg <= lvl_sat;
                PH_B:    lvl_b_reg <= lvl_sat;
                default: lvl_c_reg <= lvl_sat;
            endcase
        end
        if (cmd.out_load)
        begin
            level_a_reg <= lvl_a_reg;
            level_b_reg <= lvl_b_reg;
            level_c_reg <= lvl_c_reg;
        end
    end

    assign level_a = level_a_reg;
    assign level_b = level_b_reg;
    assign level_c = level_c_reg;

endmodule

// ----- tb/tb_three_phase_sine_pwm_reference_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_three_phase_sine_pwm_reference_unit
// Self-checking bench for the three-phase sine PWM reference unit. It runs a
// short directed table of register settings and transactions first. Then it
// runs random phases under no idling, sender gaps, receiver stalls and both.
// Every accepted input transaction is run through a local phase accumulator
// and sine table model. Each output transaction is compared with the oldest
// predicted level triple.
// ============================================================================
module tb_three_phase_sine_pwm_reference_unit;

    import spwm_pkg::*;

    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          RAND_PHASES     = 8;
    localparam int          ITEMS_PER_PHASE = 75;
    localparam logic [31:0] THIRD_TURN      = 32'd1431655765;
    localparam logic [31:0] TWO_THIRDS_TURN = 32'd2863311531;
    localparam logic [63:0] Q30_ONE         = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } levels_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One directed step: a register write or an input transaction, with the
    // levels typed in where they are obvious (known bits: c, b, a)
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        logic        adv;
        logic [2:0]  known;
        logic [15:0] la;
        logic [15:0] lb;
        logic [15:0] lc;
    } dir_row_t;

    localparam int N_ROWS = 32;

    dir_row_t dir_rows [0:N_ROWS-1] = '{
        // straight after reset: phase A sits at zero, sine 0, level = centre
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b0, 3'b001, 16'd500, 16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        // half-turn step, then a step that wraps almost a full turn
        '{ROW_CFG,  CFG_PHASE_STEP,   32'h8000_0000, 1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_PHASE_STEP,   32'hFFFF_FFFF, 1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_PHASE_STEP,   32'd0,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        // zero amplitude flattens all three levels
        '{ROW_CFG,  CFG_AMPLITUDE,    32'd0,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b111, 16'd0,   16'd0, 16'd0},
        // largest product: saturation near the crest
        '{ROW_CFG,  CFG_AMPLITUDE,    32'd32767,     1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_CARRIER_HALF, 32'd32768,     1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_PHASE_STEP,   32'h4000_0000, 1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        // zero centre
        '{ROW_CFG,  CFG_CARRIER_HALF, 32'd0,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b0, 3'b111, 16'd0,   16'd0, 16'd0},
        // smallest nonzero product rounds down to zero
        '{ROW_CFG,  CFG_CARRIER_HALF, 32'd1,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_AMPLITUDE,    32'd1,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b111, 16'd0,   16'd0, 16'd0},
        // one table entry per tick at the default scaling
        '{ROW_CFG,  CFG_PHASE_STEP,   32'd8388608,   1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_AMPLITUDE,    32'd16384,     1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_CFG,  CFG_CARRIER_HALF, 32'd500,       1'b0, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b1, 3'b000, 16'd0,   16'd0, 16'd0},
        '{ROW_ITEM, CFG_PHASE_STEP,   32'd0,         1'b0, 3'b000, 16'd0,   16'd0, 16'd0}
    };

    // DUT signals
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        advance;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] level_a;
    logic [15:0] level_b;
    logic [15:0] level_c;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // Local copy of the unit's registers and accumulator
    logic [31:0] step_r;
    logic [14:0] amp_r;
    logic [15:0] half_r;
    logic [31:0] phase_acc;
    int          sine_tab [0:511];

    levels_t     pending_levels [$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    three_phase_sine_pwm_reference_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level_a   (level_a),
        .level_b   (level_b),
        .level_c   (level_c),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Q1.15 sine of a 32-bit turn fraction, polynomial in Q30
    function automatic int sine_entry(input logic [31:0] p);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] div_by;
        int          mag;
        r = {34'd0, p[29:0]};
        if (p[30])
            r = Q30_ONE - r;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int k = 0; k < 5; k++)
        begin
            case (k)
                0:       div_by = 64'd110;
                1:       div_by = 64'd72;
                2:       div_by = 64'd42;
                3:       div_by = 64'd20;
                default: div_by = 64'd6;
            endcase
            t = Q30_ONE - ((x2 * t) >> 30) / div_by;
        end
        s = (x * t) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
            q = 64'd32767;
        mag = int'(q[15:0]);
        return p[31] ? -mag : mag;
    endfunction

    // Compare level of one phase: amplitude * half * (1 + sin), saturated
    function automatic logic [15:0] level_for(input logic [31:0] phase);
        logic [63:0] centred;
        logic [63:0] prod;
        centred = 64'(32768 + sine_tab[phase[31:23]]);
        prod    = (amp_r * half_r * centred) >> 29;
        if (prod > 64'd65535)
            prod = 64'd65535;
        return prod[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one input transaction; predict its levels once it is taken
    task automatic send_item(input logic adv, input logic [2:0] known,
                             input levels_t typed);
        levels_t lv;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            advance  = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        in_valid = 1'b1;
        advance  = adv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (adv)
            phase_acc = phase_acc + step_r;
        lv.a = known[0] ? typed.a : level_for(phase_acc);
        lv.b = known[1] ? typed.b : level_for(phase_acc + THIRD_TURN);
        lv.c = known[2] ? typed.c : level_for(phase_acc + TWO_THIRDS_TURN);
        pending_levels.push_back(lv);
    endtask

    // Stop sending and wait for every predicted result to come out
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_levels.size() != 0)
            @(negedge clk);
    endtask

    // Register write, only once the unit is idle
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        repeat (3) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            CFG_PHASE_STEP:   step_r = val;
            CFG_AMPLITUDE:    amp_r  = val[14:0];
            CFG_CARRIER_HALF: half_r = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Sine table of the model
    initial
    begin
        for (int i = 0; i < 512; i++)
            sine_tab[i] = sine_entry(i << 23);
    end

    // Receiver stalls
    initial out_stall = 1'b0;
    always @(negedge clk)
        out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    // Output checker
    always @(posedge clk)
    begin : check_levels
        levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch("unexpected transaction, level_a", level_a, 16'd0);
            end
            else
            begin
                want = pending_levels.pop_front();
                if (level_a !== want.a)
                    report_mismatch("level_a", level_a, want.a);
                if (level_b !== want.b)
                    report_mismatch("level_b", level_b, want.b);
                if (level_c !== want.c)
                    report_mismatch("level_c", level_c, want.c);
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("** three_phase_sine_pwm_reference_unit: FAILED **");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin : main
        logic [31:0] step_pick;
        logic [31:0] amp_pick;
        logic [31:0] half_pick;
        levels_t     typed;
        in_valid      = 1'b0;
        advance       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_PHASE_STEP;
        cfg_data      = 32'd0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        step_r        = 32'd429497;
        amp_r         = 15'd16384;
        half_r        = 16'd500;
        phase_acc     = 32'd0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, no idling
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
            begin
                typed.a = dir_rows[i].la;
                typed.b = dir_rows[i].lb;
                typed.c = dir_rows[i].lc;
                send_item(dir_rows[i].adv, dir_rows[i].known, typed);
            end
        end

        // Random phases: fresh settings, then transactions under one idling mode
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(0, 4))
                0:       step_pick = $urandom_range(0, 1 << 20);
                1:       step_pick = $urandom;
                2:       step_pick = $urandom_range(0, 511) << 23;
                3:       step_pick = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
                default: step_pick = 32'h4000_0000 + $urandom_range(0, 255) - 128;
            endcase
            case ($urandom_range(0, 3))
                0:       amp_pick = $urandom_range(0, 1) ? 32'd32767 : 32'd0;
                1:       amp_pick = 32'd16384;
                default: amp_pick = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 3))
                0:       half_pick = $urandom_range(0, 1) ? 32'd32768 : 32'd0;
                1:       half_pick = $urandom_range(1, 1000);
                default: half_pick = $urandom_range(1, 32768);
            endcase
            // force the extremes at least once
            if (ph == 3)
            begin
                amp_pick  = 32'd32767;
                half_pick = 32'd32768;
            end
            if (ph == 7)
                half_pick = 32'd1;
            set_reg(CFG_PHASE_STEP, step_pick);
            set_reg(CFG_AMPLITUDE, amp_pick);
            set_reg(CFG_CARRIER_HALF, half_pick);

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 45;
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // mid-phase: let the pipe run dry before going on
                if (i == ITEMS_PER_PHASE / 2)
                    drain();
                send_item($urandom_range(0, 3) != 0, 3'b000, '0);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("** three_phase_sine_pwm_reference_unit: PASSED **");
        else
            $display("** three_phase_sine_pwm_reference_unit: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/spwm_pkg.sv
rtl/spwm_ctrl.sv
rtl/spwm_datapath.sv
rtl/three_phase_sine_pwm_reference_unit.sv
tb/tb_three_phase_sine_pwm_reference_unit.sv
